// ----- src/psc_pkg.sv -----
// Shared constants for the parabolic sine/cosine block.
package psc_pkg;

  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 16;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF   = 14;

  // pi and pi/2 in Q32, 4/pi and 4/pi^2 in Q30
  localparam longint PI_Q32            = 64'sd13493037705;
  localparam longint HALF_PI_Q32       = 64'sd6746518852;
  localparam longint FOUR_OVER_PI_Q30  = 64'sd1367130551;
  localparam longint FOUR_OVER_PI2_Q30 = 64'sd435171170;

  // width of the biased, non-negative angle fed to the wrap
  localparam int WRAP_W = 33;

endpackage

// ----- src/parabolic_sine_cosine.sv -----
// Parabolic sine/cosine approximation: ten-stage pipeline, one request per cycle while the receiver does not stall.
//
// Input channel (s_axis): tdata carries the angle in radians, signed fixed
// point with ANGLE_FRAC_BITS fraction bits; tuser selects sine (0) or cosine (1).
// Output channel (m_axis): tdata carries the result, signed with OUT_FRAC_BITS
// fraction bits, clamped to +-1.0 and to 16 bits.
// A request is taken on every edge where tvalid and tready are both high.
//
// A result moves through the stage registers in order, stage 1 to stage 10,
// and shows on m_axis while it sits in stage 10.
// Throughput is one request per cycle while the receiver does not stall.
//
// Each stage holds its own valid bit and loads when it is empty or the stage
// after it moves, so a stalled receiver freezes only the full stages and
// s_axis_tready stays high while any bubble is left in the pipe. Nothing is
// dropped or repeated under stall.
//
// Reset clears all valid bits; the pipe is empty and ready after reset.
module parabolic_sine_cosine
  import psc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [ANGLE_W-1:0] s_axis_tdata_i,  // [31:0] angle
  input  logic               s_axis_tuser_i,  // [0] cmd
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [VALUE_W-1:0] m_axis_tdata_o   // [15:0] value
);

  localparam int N  = 10;
  localparam int F  = ANGLE_FRAC_BITS;
  localparam int UW = WRAP_W;

  // angle-format constants, rounded half up from Q32
  localparam longint PiA     = (PI_Q32 + (64'sd1 <<< (31 - F))) >>> (32 - F);
  localparam longint HalfPiA = (HALF_PI_Q32 + (64'sd1 <<< (31 - F))) >>> (32 - F);
  localparam longint WrapMod = 2 * PiA;

  // bias by a multiple of 2*pi so the wrap only sees non-negative values
  localparam longint BiasK = ((64'sd1 <<< 31) + WrapMod - 1) / WrapMod;
  localparam longint Bias  = BiasK * WrapMod;

  // reciprocal of 2*pi; the quotient estimate is low by at most one
  localparam longint Recip = (64'sd1 <<< UW) / WrapMod;
  localparam int     RW    = $clog2(Recip + 1);
  localparam int     MW    = $clog2(WrapMod + 1);
  localparam int     XW    = MW;
  localparam int     AW    = XW - 1;
  localparam int     QW    = 2 * AW - F + 1;
  localparam int     PW1   = XW + 32;
  localparam int     PW2   = QW + 29;
  localparam int     SW    = ((PW1 > PW2 + 1) ? PW1 : PW2 + 1) + 1;
  localparam int     SH    = F + 30 - OUT_FRAC_BITS;

  localparam longint LimO     = 64'sd1 <<< OUT_FRAC_BITS;
  localparam longint ClampHi  = (LimO > 32767) ? 64'sd32767 : LimO;
  localparam longint ClampLo  = (-LimO < -32768) ? -64'sd32768 : -LimO;

  localparam logic [RW-1:0]          RECIP_V = RW'(Recip);
  localparam logic [MW-1:0]          MOD_V   = MW'(WrapMod);
  localparam logic signed [MW+1:0]   MOD_S   = (MW + 2)'(WrapMod);
  localparam logic signed [MW+1:0]   PIA_S   = (MW + 2)'(PiA);
  localparam logic signed [31:0]     C1_S    = 32'(FOUR_OVER_PI_Q30);
  localparam logic [28:0]            C2_U    = 29'(FOUR_OVER_PI2_Q30);
  localparam logic [2*AW:0]          RND_F   = (2 * AW + 1)'(64'sd1 <<< (F - 1));
  localparam logic signed [SW:0]     RND_SH  = (SW + 1)'(64'sd1 <<< (SH - 1));
  localparam logic signed [SW:0]     HI_S    = (SW + 1)'(ClampHi);
  localparam logic signed [SW:0]     LO_S    = (SW + 1)'(ClampLo);

  // handshake
  logic [N:1]   v_q;
  logic [N+1:1] rdy;
  logic [N:1]   vin;

  always_comb begin
    rdy[N+1] = m_axis_tready_i;
    for (int k = N; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign vin = {v_q[N-1:1], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (vin & rdy[N:1]) | (v_q & ~rdy[N:1]);
    end
  end

  assign s_axis_tready_o = rdy[1];
  assign m_axis_tvalid_o = v_q[N];

  // stage 1: cosine offset, +pi and bias
  logic signed [63:0] a_ext;
  logic [UW-1:0]      u1_d, u1_q;

  assign a_ext = {{(64 - ANGLE_W){s_axis_tdata_i[ANGLE_W-1]}}, s_axis_tdata_i};
  assign u1_d  = UW'(a_ext + (s_axis_tuser_i ? HalfPiA : 64'sd0) + PiA + Bias);

  // stage 2: quotient estimate
  logic [UW+RW-1:0] prod1;
  logic [RW-1:0]    k2_q;
  logic [UW-1:0]    u2_q;

  assign prod1 = (UW + RW)'(u1_q) * (UW + RW)'(RECIP_V);

  // stage 3: quotient times 2*pi
  logic [RW+MW-1:0] km_full;
  logic [UW-1:0]    km3_q, u3_q;

  assign km_full = (RW + MW)'(k2_q) * (RW + MW)'(MOD_V);

  // stage 4: remainder in [0, 4*pi)
  logic [MW:0] r4_d, r4_q;

  assign r4_d = (MW + 1)'(u3_q - km3_q);

  // stage 5: final correction and -pi
  logic signed [MW+1:0] rs;
  logic signed [XW-1:0] x5_d, x5_q;

  assign rs   = signed'({1'b0, r4_q});
  assign x5_d = XW'((rs >= MOD_S) ? (rs - MOD_S - PIA_S) : (rs - PIA_S));

  // stage 6: x squared
  logic [AW-1:0]        ax;
  logic [2*AW-1:0]      sq6_d, sq6_q;
  logic signed [XW-1:0] x6_q;

  assign ax    = AW'(x5_q[XW-1] ? -x5_q : x5_q);
  assign sq6_d = (2 * AW)'(ax) * (2 * AW)'(ax);

  // stage 7: round x*x, 4/pi * x
  logic [2*AW:0]         sqr;
  logic [QW-1:0]         q7_q;
  logic signed [PW1-1:0] p1_7_d, p1_7_q;
  logic                  neg7_q;

  assign sqr    = {1'b0, sq6_q} + RND_F;
  assign p1_7_d = PW1'(x6_q) * PW1'(C1_S);

  // stage 8: 4/pi^2 * round(x*x)
  logic [PW2-1:0]        p2_8_d, p2_8_q;
  logic signed [PW1-1:0] p1_8_q;
  logic                  neg8_q;

  assign p2_8_d = PW2'(q7_q) * PW2'(C2_U);

  // stage 9: combine terms, sign of the square term is opposite to that of x
  logic signed [SW-1:0] p1_s, p2_s, s9_d, s9_q;

  assign p1_s = SW'(p1_8_q);
  assign p2_s = SW'(signed'({1'b0, p2_8_q}));
  assign s9_d = neg8_q ? (p1_s + p2_s) : (p1_s - p2_s);

  // stage 10: round half up, clamp
  logic signed [SW:0]   yr, ysh;
  logic [VALUE_W-1:0]   y10_d, y10_q;

  assign yr  = (SW + 1)'(s9_q) + RND_SH;
  assign ysh = yr >>> SH;

  always_comb begin
    if (ysh > HI_S) begin
      y10_d = VALUE_W'(HI_S);
    end else if (ysh < LO_S) begin
      y10_d = VALUE_W'(LO_S);
    end else begin
      y10_d = ysh[VALUE_W-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      u1_q <= u1_d;
    end
    if (rdy[2]) begin
      k2_q <= prod1[UW+RW-1:UW];
      u2_q <= u1_q;
    end
    if (rdy[3]) begin
      km3_q <= km_full[UW-1:0];
      u3_q  <= u2_q;
    end
    if (rdy[4]) begin
      r4_q <= r4_d;
    end
    if (rdy[5]) begin
      x5_q <= x5_d;
    end
    if (rdy[6]) begin
      sq6_q <= sq6_d;
      x6_q  <= x5_q;
    end
    if (rdy[7]) begin
      q7_q   <= sqr[2*AW:F];
      p1_7_q <= p1_7_d;
      neg7_q <= x6_q[XW-1];
    end
    if (rdy[8]) begin
      p2_8_q <= p2_8_d;
      p1_8_q <= p1_7_q;
      neg8_q <= neg7_q;
    end
    if (rdy[9]) begin
      s9_q <= s9_d;
    end
    if (rdy[10]) begin
      y10_q <= y10_d;
    end
  end

  assign m_axis_tdata_o = y10_q;

endmodule
